/* sv/ebmm_pkg.sv */
// Package for the energy burst mean marker: field widths, register
// indexes, reset values and the control/status structs.
// No dependencies.
package ebmm_pkg;

    // Field widths
    localparam int ENERGY_W   = 32;
    localparam int MARKER_W   = 32;
    localparam int THR_W      = 32;
    localparam int MIN_RUN_W  = 6;
    localparam int MAX_RUN_W  = 7;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 2'd2;

    // Register reset values
    localparam logic [THR_W-1:0]     THRESHOLD_RST = 32'd200000;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST   = 6'd3;
    localparam logic [MAX_RUN_W-1:0] MAX_RUN_RST   = 7'd50;

    // Longest run the block tracks
    localparam int MAX_RUN_LIMIT_DEF = 64;

    // Controller to datapath
    typedef struct packed {
        logic load;   // input transaction taken
        logic pop;    // output transaction taken
    } ebmm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;   // accepted item needs the run mean
        logic has_result; // accepted item produces at least one result
        logic div_done;   // quotient ready
        logic last;       // current result is the final one
    } ebmm_status_t;

endpackage

/* sv/ebmm_if.sv */
// Valid/ready channel interfaces for samples in and markers out.
// Depends on ebmm_pkg.
interface ebmm_sample_if;
    logic                          valid;
    logic                          ready;
    logic [ebmm_pkg::ENERGY_W-1:0] energy;
    logic                          flush;

    modport source (output valid, output energy, output flush, input ready);
    modport sink   (input valid, input energy, input flush, output ready);
endinterface

interface ebmm_marker_if;
    logic                          valid;
    logic                          ready;
    logic [ebmm_pkg::MARKER_W-1:0] marker;
    logic                          last;

    modport source (output valid, output marker, output last, input ready);
    modport sink   (input valid, input marker, input last, output ready);
endinterface

/* sv/ebmm_div.sv */
// Restoring divider, one quotient bit per cycle.
// Standalone; used by ebmm_datapath for the run mean.
module ebmm_div #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    // One shift/subtract step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = shifted >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIVIDEND_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(shifted - {1'b0, div_reg})
                            : DIVISOR_W'(shifted);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* sv/ebmm_datapath.sv */
// Datapath: configuration registers, run state, result counters, mean divider.
// Depends on ebmm_pkg and ebmm_div.
module ebmm_datapath #(
    parameter int MAX_RUN_LIMIT = ebmm_pkg::MAX_RUN_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ebmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ebmm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [ebmm_pkg::ENERGY_W-1:0]   energy,
    input  logic                            flush,
    input  ebmm_pkg::ebmm_cmd_t             cmd,
    output ebmm_pkg::ebmm_status_t          status,
    output logic [ebmm_pkg::MARKER_W-1:0]   marker,
    output logic                            last
);
    import ebmm_pkg::*;

    localparam int LEN_W = $clog2(MAX_RUN_LIMIT + 1);
    localparam int TOT_W = ENERGY_W + $clog2(MAX_RUN_LIMIT);
    localparam int CNT_W = $clog2(MAX_RUN_LIMIT + 2);

    // Configuration
    logic [THR_W-1:0]     thr_reg;
    logic [MIN_RUN_W-1:0] min_reg;
    logic [MAX_RUN_W-1:0] max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RST;
            min_reg <= MIN_RUN_RST;
            max_reg <= MAX_RUN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                REG_MIN_RUN:   min_reg <= cfg_data[MIN_RUN_W-1:0];
                REG_MAX_RUN:   max_reg <= cfg_data[MAX_RUN_W-1:0];
                default:       ;
            endcase
        end
    end

    // Run state
    logic [LEN_W-1:0] len_reg, len_next;
    logic [TOT_W-1:0] tot_reg, tot_next;
    logic             long_reg, long_next;

    // Result bookkeeping
    logic [CNT_W-1:0]    mean_cnt_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [MARKER_W-1:0] mean_reg;

    logic [MAX_RUN_W-1:0] eff_max;
    logic [MAX_RUN_W-1:0] len_cmp;
    logic [MAX_RUN_W-1:0] inc_cmp;
    logic [LEN_W-1:0]     len_inc;
    logic [TOT_W-1:0]     tot_inc;
    logic                 above;
    logic                 pending;
    logic                 qualify;
    logic [LEN_W-1:0]     plan_cnt;
    logic                 plan_extra;
    logic                 plan_div;

    logic [TOT_W-1:0]     quotient;
    logic                 div_done;

    // Plan for the item on the input
    always_comb
    begin
        eff_max = (max_reg > MAX_RUN_W'(MAX_RUN_LIMIT)) ? MAX_RUN_W'(MAX_RUN_LIMIT)
                                                        : max_reg;
        len_cmp = MAX_RUN_W'(len_reg);
        len_inc = len_reg + 1'b1;
        inc_cmp = MAX_RUN_W'(len_inc);
        tot_inc = tot_reg + TOT_W'(energy);
        above   = energy > thr_reg;
        pending = !long_reg && (len_reg != '0);
        qualify = (len_cmp > MAX_RUN_W'(min_reg)) && (len_cmp < eff_max);

        plan_cnt   = '0;
        plan_extra = 1'b0;
        plan_div   = 1'b0;
        len_next   = len_reg;
        tot_next   = tot_reg;
        long_next  = long_reg;

        priority if (flush || !above)
        begin
            // run closes: release pending samples, one zero for a quiet sample
            plan_cnt   = pending ? len_reg : '0;
            plan_div   = pending && qualify;
            plan_extra = !flush;
            len_next   = '0;
            tot_next   = '0;
            long_next  = 1'b0;
        end
        else if (long_reg)
        begin
            plan_extra = 1'b1;
        end
        else
        begin
            len_next = len_inc;
            tot_next = tot_inc;
            if (inc_cmp >= eff_max)
            begin
                // run hit the maximum: all its samples get zero now
                plan_cnt  = len_inc;
                long_next = 1'b1;
                tot_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            tot_reg  <= '0;
            long_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            len_reg  <= len_next;
            tot_reg  <= tot_next;
            long_reg <= long_next;
        end
    end

    // Mean of the closing run
    ebmm_div #(
        .DIVIDEND_W (TOT_W),
        .DIVISOR_W  (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load && plan_div),
        .dividend (tot_reg),
        .divisor  (len_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Result counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_cnt_reg <= '0;
            rem_reg      <= '0;
        end
        else if (cmd.load)
        begin
            mean_cnt_reg <= CNT_W'(plan_cnt);
            rem_reg      <= CNT_W'(plan_cnt) + CNT_W'(plan_extra);
        end
        else if (cmd.pop)
        begin
            rem_reg <= rem_reg - 1'b1;
            if (mean_cnt_reg != '0)
            begin
                mean_cnt_reg <= mean_cnt_reg - 1'b1;
            end
        end
    end

    // Mean value; zero unless the run qualified
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mean_reg <= '0;
        end
        else if (div_done)
        begin
            mean_reg <= quotient[MARKER_W-1:0];
        end
    end

    assign marker = (mean_cnt_reg != '0) ? mean_reg : '0;
    assign last   = (rem_reg == CNT_W'(1));

    assign status.need_div   = plan_div;
    assign status.has_result = (plan_cnt != '0) || plan_extra;
    assign status.div_done   = div_done;
    assign status.last       = last;

endmodule

/* sv/ebmm_ctrl.sv */
// Controller: accepts one item, waits for the mean if needed, then
// drains its results. Depends on ebmm_pkg.
module ebmm_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  ebmm_pkg::ebmm_status_t status,
    output ebmm_pkg::ebmm_cmd_t    cmd
);
    import ebmm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.pop   = out_valid && out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    priority if (status.need_div)
                        state_next = S_DIV;
                    else if (status.has_result)
                        state_next = S_EMIT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cmd.pop && status.last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/energy_burst_mean_marker.sv */
// Energy burst mean marker: top level joining controller and datapath.
// Depends on ebmm_pkg, ebmm_if, ebmm_ctrl and ebmm_datapath.
//
// One sample is handled at a time. A sample that causes no result leaves the
// block ready for the next one; a sample that causes results gives them out
// one per cycle (up to MAX_RUN_LIMIT results) while the output is ready. When
// a run that qualifies closes, its mean comes from a restoring divider that
// produces one quotient bit per cycle over the run sum, and the first result
// waits for it. Results for a run are held until the run closes (a quiet
// sample or a flush) or reaches the maximum length; a flush yields no result
// of its own.
module energy_burst_mean_marker #(
    parameter int MAX_RUN_LIMIT = ebmm_pkg::MAX_RUN_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ebmm_sample_if.sink                     samples,
    ebmm_marker_if.source                   markers,
    input  logic                            cfg_we,
    input  logic [ebmm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ebmm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ebmm_pkg::*;

    ebmm_cmd_t    cmd;
    ebmm_status_t status;

    ebmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (markers.valid),
        .out_ready (markers.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ebmm_datapath #(
        .MAX_RUN_LIMIT (MAX_RUN_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .energy    (samples.energy),
        .flush     (samples.flush),
        .cmd       (cmd),
        .status    (status),
        .marker    (markers.marker),
        .last      (markers.last)
    );

endmodule

/* test/testbench.sv */
// Testbench for energy_burst_mean_marker: a directed table, then random bursts under
// several register settings, every marker checked against an in-bench burst predictor or a typed literal.
// Depends on ebmm_pkg, ebmm_if and the energy_burst_mean_marker RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ebmm_pkg::*;

    localparam int RUN_LIMIT     = MAX_RUN_LIMIT_DEF;
    localparam int SETTLE_CYCLES = 160;      // divide plus a full run of results
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;

    // Index that selects no register; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MARKER_W-1:0] marker;
        logic                last;
    } marker_t;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_FLUSH, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [31:0]          value;    // energy, or register data
        logic [CFG_IDX_W-1:0] idx;
        logic                 lit;      // expected marker typed in below
        logic [MARKER_W-1:0]  lit_m;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ebmm_sample_if sample_ch ();
    ebmm_marker_if marker_ch ();

    energy_burst_mean_marker #(.MAX_RUN_LIMIT(RUN_LIMIT)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .markers   (marker_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Register copy and burst state of the predictor
    logic [THR_W-1:0]     thr_q = THRESHOLD_RST;
    logic [MIN_RUN_W-1:0] min_q = MIN_RUN_RST;
    logic [MAX_RUN_W-1:0] max_q = MAX_RUN_RST;
    logic [6:0]  burst_len    = '0;
    logic [37:0] burst_sum    = '0;
    logic        burst_capped = 1'b0;

    marker_t   due_markers[$];
    stim_row_t directed[$];

    // Literal expectation travels with the sample transaction
    logic                lit_row = 1'b0;
    logic [MARKER_W-1:0] lit_marker = '0;

    int errors = 0;
    int cycles = 0;
    int samples_taken = 0;
    int markers_seen = 0;
    int settings_run = 0;
    int snd_idle = 24;
    int rcv_idle = 75;
    int stall_req = 0;

    // Predictor
    function automatic logic [6:0] run_cap();
        return (max_q > 7'(RUN_LIMIT)) ? 7'(RUN_LIMIT) : max_q;
    endfunction

    function automatic void append_due(input marker_t item);
        due_markers = {due_markers, item};
    endfunction

    function automatic void queue_marker(input logic [MARKER_W-1:0] m);
        marker_t item;
        item = '{marker: m, last: 1'b0};
        append_due(item);
    endfunction

    function automatic void close_burst();
        logic [MARKER_W-1:0] mean;
        mean = '0;
        if (!burst_capped && burst_len != 0)
        begin
            if (burst_len > {1'b0, min_q} && burst_len < run_cap())
                mean = MARKER_W'(burst_sum / {31'd0, burst_len});
            repeat (burst_len) queue_marker(mean);
        end
        burst_len    = '0;
        burst_sum    = '0;
        burst_capped = 1'b0;
    endfunction

    function automatic void mark_sample(input logic [ENERGY_W-1:0] e, input logic fl);
        int first;
        first = due_markers.size();
        if (fl)
        begin
            close_burst();
        end
        else if (e > thr_q)
        begin
            if (burst_capped)
            begin
                queue_marker('0);
            end
            else
            begin
                burst_len = burst_len + 7'd1;
                burst_sum = burst_sum + {6'd0, e};
                // run hit the maximum: all its zeros go out now
                if (burst_len >= run_cap())
                begin
                    repeat (burst_len) queue_marker('0);
                    burst_capped = 1'b1;
                    burst_sum    = '0;
                end
            end
        end
        else
        begin
            close_burst();
            queue_marker('0);
        end
        if (due_markers.size() > first)
            due_markers[$].last = 1'b1;
    endfunction

    task automatic flag_error(input string what, input marker_t want, input marker_t got);
        errors++;
        if (errors <= 10)
            $display("[%0t] %s: expected marker %0d last %0b, got marker %0d last %0b",
                     $time, what, want.marker, want.last, got.marker, got.last);
    endtask

    // Monitor: predict on every sample transaction, check every marker transaction
    always @(posedge clk)
    begin
        int      prior_count;
        marker_t want;
        marker_t got;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                prior_count = due_markers.size();
                mark_sample(sample_ch.energy, sample_ch.flush);
                if (lit_row)
                begin
                    while (due_markers.size() > prior_count)
                        void'(due_markers.pop_back());
                    want = '{marker: lit_marker, last: 1'b1};
                    append_due(want);
                end
                samples_taken++;
            end
            if (marker_ch.valid && marker_ch.ready)
            begin
                markers_seen++;
                got = '{marker: marker_ch.marker, last: marker_ch.last};
                if (due_markers.size() == 0)
                begin
                    flag_error("marker with nothing outstanding", '0, got);
                end
                else
                begin
                    want = due_markers.pop_front();
                    if (want.marker !== got.marker || want.last !== got.last)
                        flag_error("marker mismatch", want, got);
                end
            end
        end
    end

    // Receiver: random ready, plus a long hold-off on request
    always @(posedge clk)
    begin
        int hold_left;
        if (!rst_n)
        begin
            marker_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (stall_req != 0)
            begin
                hold_left = stall_req;
                stall_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                marker_ch.ready <= 1'b0;
            end
            else
            begin
                marker_ch.ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one sample transaction and wait until it is taken
    task automatic offer_sample(input logic [ENERGY_W-1:0] e, input logic fl,
                                input logic lit, input logic [MARKER_W-1:0] lit_m);
        while ($urandom_range(99) < snd_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.energy <= e;
        sample_ch.flush  <= fl;
        lit_row          <= lit;
        lit_marker       <= lit_m;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // Let every outstanding marker drain, then let the divider go quiet
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_markers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Caller lowers cfg_we after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        unique case (idx)
            REG_THRESHOLD: thr_q = data;
            REG_MIN_RUN:   min_q = data[MIN_RUN_W-1:0];
            REG_MAX_RUN:   max_q = data[MAX_RUN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [ENERGY_W-1:0] hot_energy();
        logic [63:0] lo;
        lo = {32'd0, thr_q} + 64'd1;
        unique case ($urandom_range(7))
            0:       return lo[31:0];
            1:       return '1;
            default: return 32'(lo + ({32'd0, $urandom} % (64'h1_0000_0000 - lo)));
        endcase
    endfunction

    function automatic logic [ENERGY_W-1:0] quiet_energy();
        unique case ($urandom_range(7))
            0:       return thr_q;
            1:       return '0;
            default: return 32'({32'd0, $urandom} % ({32'd0, thr_q} + 64'd1));
        endcase
    endfunction

    // Mostly well-formed bursts closed by a quiet sample or a flush; some noise
    task automatic random_bursts(input int items);
        int sent;
        int pick;
        int len;
        int cap;
        sent = 0;
        while (sent < items)
        begin
            pick = $urandom_range(99);
            cap  = run_cap();
            if (pick < 80 && thr_q != '1)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(6, 1);
                else if (pick < 90)
                    len = $urandom_range(cap + 1, 1);
                else
                    len = cap + $urandom_range(3);
                repeat (len) offer_sample(hot_energy(), 1'b0, 1'b0, '0);
                if ($urandom_range(3) == 0)
                    offer_sample($urandom, 1'b1, 1'b0, '0);
                else
                    offer_sample(quiet_energy(), 1'b0, 1'b0, '0);
                sent += len + 1;
            end
            else if (pick < 92)
            begin
                offer_sample($urandom, 1'b0, 1'b0, '0);
                sent++;
            end
            else
            begin
                offer_sample($urandom, 1'b1, 1'b0, '0);
            end
        end
    endtask

    task automatic run_setting(input logic [31:0] thr, input logic [31:0] mn,
                               input logic [31:0] mx, input int sidle, input int ridle,
                               input int hold, input int items);
        settle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_MIN_RUN, mn);
        write_reg(REG_MAX_RUN, mx);
        cfg_we   <= 1'b0;
        snd_idle  = sidle;
        rcv_idle  = ridle;
        stall_req = hold;
        settings_run++;
        random_bursts(items);
        // close whatever run is still open
        offer_sample('1, 1'b1, 1'b0, '0);
    endtask

    // Directed table builders
    function automatic void add_row(input stim_row_t row);
        directed = {directed, row};
    endfunction

    function automatic void add_sample(input logic [31:0] e, input logic lit,
                                       input logic [MARKER_W-1:0] lit_m);
        add_row('{kind: ROW_SAMPLE, value: e, idx: '0, lit: lit, lit_m: lit_m});
    endfunction

    function automatic void add_flush();
        add_row('{kind: ROW_FLUSH, value: '1, idx: '0, lit: 1'b0, lit_m: '0});
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        add_row('{kind: ROW_CONFIG, value: data, idx: idx, lit: 1'b0, lit_m: '0});
    endfunction

    initial
    begin
        sample_ch.valid  = 1'b0;
        sample_ch.energy = '0;
        sample_ch.flush  = 1'b0;
        marker_ch.ready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // Reset register values first
        add_sample(32'd0, 1'b1, '0);            // minimum energy
        add_flush();                            // nothing pending
        add_sample(32'd200000, 1'b1, '0);       // at threshold is not above it
        repeat (4) add_sample('1, 1'b0, '0);    // qualifying run at maximum energy
        add_flush();
        add_sample(32'd200001, 1'b0, '0);       // run too short to mark
        add_sample(32'd300000, 1'b0, '0);
        add_sample(32'd250000, 1'b0, '0);
        add_sample(32'd7, 1'b0, '0);
        // Masked writes: max 3, min 0
        add_cfg(REG_MAX_RUN, 32'hFFFF_FF83);
        add_cfg(REG_MIN_RUN, 32'hFFFF_FFC0);
        add_sample(32'd1000000, 1'b0, '0);
        add_sample(32'd3000000, 1'b0, '0);
        add_sample(32'd0, 1'b0, '0);
        repeat (3) add_sample(32'd900000, 1'b0, '0);  // reaches the maximum
        add_sample(32'd900001, 1'b1, '0);       // run already too long
        add_flush();                            // flush of a too-long run
        add_cfg(REG_UNUSED, 32'd1);
        add_cfg(REG_MAX_RUN, 32'd1);            // every run too long at once
        add_sample('1, 1'b1, '0);
        add_sample(32'd0, 1'b1, '0);
        add_cfg(REG_THRESHOLD, '1);             // nothing can exceed it
        add_sample('1, 1'b1, '0);
        add_cfg(REG_THRESHOLD, 32'd0);
        add_cfg(REG_MAX_RUN, 32'd127);          // saturates to the run limit
        add_sample(32'd1, 1'b0, '0);            // single-sample run qualifies
        add_sample(32'd0, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        settings_run++;
        foreach (directed[i])
        begin
            unique case (directed[i].kind)
                ROW_CONFIG:
                begin
                    settle();
                    write_reg(directed[i].idx, directed[i].value);
                    cfg_we <= 1'b0;
                end
                ROW_FLUSH:
                    offer_sample(directed[i].value, 1'b1, 1'b0, '0);
                default:
                    offer_sample(directed[i].value, 1'b0, directed[i].lit, directed[i].lit_m);
            endcase
        end

        // Random part: sender light and receiver heavy idling, then swapped, then none
        run_setting(32'd1000, 32'd2, 32'd8, 24, 75, HOLD_CYCLES, 45);
        run_setting(32'd0, 32'd0, 32'd127, 24, 75, 0, 55);
        run_setting($urandom, 32'd63, 32'd64, 75, 24, 0, 45);
        run_setting(32'hFFFF_FFFE, 32'd5, 32'd5, 75, 24, 0, 40);
        run_setting(32'd200000, 32'd3, 32'd50, 0, 0, 0, 45);
        run_setting(32'd16, 32'd0, 32'd0, 0, 0, 0, 30);
        run_setting($urandom, $urandom, $urandom, 0, 0, 0, 65);

        settle();
        if (due_markers.size() != 0)
            errors++;

        $display("Ran %0d sample transactions under %0d register settings, checked %0d markers,",
                 samples_taken, settings_run, markers_seen);
        $display("with idling on both channels and one long marker hold-off.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
